@@ hw/rtl/sppi_pkg.sv @@
// shared constants, codes and controller/datapath interface types for the peak interpolator
package sppi_pkg;

	localparam int MAX_BINS  = 4096;
	localparam int MAG_BITS  = 24;
	localparam int FRAC_BITS = 16;

	localparam int BIN_W = 12;
	localparam int N_W   = 13;
	localparam int VAL_W = 34;
	localparam int IDX_W = 29;
	localparam int ST_W  = 2;

	localparam int D_W    = MAG_BITS + 3;
	localparam int DIFF_W = MAG_BITS + 1;
	localparam int DEN_W  = MAG_BITS + 2;
	localparam int Q_W    = FRAC_BITS + 1;
	localparam int DVD_W  = MAG_BITS + FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(Q_W);
	localparam int PROD_W = MAG_BITS + Q_W;
	localparam int RSH    = FRAC_BITS - 6;
	localparam int M_W    = PROD_W + 1 - RSH;
	localparam int OFF_W  = FRAC_BITS + 2;
	localparam int IRAW_W = BIN_W + FRAC_BITS + 2;
	localparam int CV_W   = MAG_BITS + 8;
	localparam int VPAD   = VAL_W - CV_W;
	localparam int MPAD   = VAL_W - M_W;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [ST_W-1:0] ST_NORMAL = 2'd0;
	localparam logic [ST_W-1:0] ST_ZERO   = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT    = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE  = 2'd3;

	localparam logic [1:0] RD_C = 2'd0;
	localparam logic [1:0] RD_L = 2'd1;
	localparam logic [1:0] RD_R = 2'd2;

	typedef struct packed {
		logic       wr;
		logic       load;
		logic [1:0] rd_sel;
		logic       cap_c;
		logic       cap_l;
		logic       cap_r;
		logic       arith;
		logic       setup;
		logic       div_step;
		logic       mul;
		logic       rnd;
		logic       fin;
	} sppi_cmd_t;

	typedef struct packed {
		logic oob;
		logic skip;
		logic div_done;
	} sppi_stat_t;

endpackage

@@ hw/rtl/sppi_dp.sv @@
// datapath: spectrum memory, config register, parabola fit, iterative divider, result registers
module sppi_dp import sppi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  sppi_cmd_t           cmd,
	output sppi_stat_t          stat,
	input  logic [BIN_W-1:0]    bin,
	input  logic [MAG_BITS-1:0] magnitude,
	input  logic                cfg_we,
	input  logic [N_W-1:0]      cfg_wdata,
	output logic                result_valid,
	output logic [VAL_W-1:0]    peak_value,
	output logic [IDX_W-1:0]    peak_index,
	output logic [ST_W-1:0]     status
);

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ZERO   = 2'd1;
	localparam logic [1:0] MODE_SAT    = 2'd2;

	logic [MAG_BITS-1:0] mem [MAX_BINS];
	logic [MAG_BITS-1:0] rdata_q;

	logic [N_W-1:0]   bins_q;
	logic [N_W-1:0]   n_eff;
	logic [N_W-1:0]   n_m1;
	logic [BIN_W-1:0] bin_q;
	logic [BIN_W-1:0] l_addr;
	logic [BIN_W-1:0] r_addr;
	logic [BIN_W-1:0] rd_addr;

	logic [MAG_BITS-1:0] c_q, l_q, r_q;
	logic signed [D_W-1:0]    d_q;
	logic signed [DIFF_W-1:0] diff_q;

	logic [D_W-1:0]      dabs;
	logic [DIFF_W-1:0]   diffabs;
	logic [MAG_BITS-1:0] num_c;
	logic [DEN_W-1:0]    den_c;
	logic [DVD_W-1:0]    dividend;
	logic [1:0]          mode_c;

	logic [MAG_BITS-1:0] num_q;
	logic [DEN_W-1:0]    den_q;
	logic [1:0]          mode_q;
	logic                neg_q;
	logic                dneg_q;

	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   dvd_q;
	logic [Q_W-1:0]   q_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic             qbit;

	logic [PROD_W-1:0]        prod_q;
	logic [PROD_W:0]          prod_rnd;
	logic [M_W-1:0]           m_q;
	logic signed [OFF_W-1:0]  off;
	logic signed [IRAW_W-1:0] base;
	logic signed [IRAW_W-1:0] idx_raw_q;
	logic signed [IRAW_W-1:0] nlim;
	logic signed [IRAW_W-1:0] idx_w;
	logic [CV_W-1:0]          cv;
	logic [VAL_W-1:0]         value_c;
	logic [ST_W-1:0]          status_c;

	logic                     valid_q;
	logic [VAL_W-1:0]         value_q;
	logic [IDX_W-1:0]         index_q;
	logic [ST_W-1:0]          status_q;

	// config register and bin count clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= N_W'(MAX_BINS);
		end else if (cfg_we) begin
			bins_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (bins_q < N_W'(3)) begin
			n_eff = N_W'(3);
		end else if (bins_q > N_W'(MAX_BINS)) begin
			n_eff = N_W'(MAX_BINS);
		end else begin
			n_eff = bins_q;
		end
	end

	assign n_m1   = n_eff - N_W'(1);
	assign l_addr = (bin_q == '0) ? n_m1[BIN_W-1:0] : bin_q - BIN_W'(1);
	assign r_addr = ({1'b0, bin_q} == n_m1) ? '0 : bin_q + BIN_W'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_C:    rd_addr = bin_q;
			RD_L:    rd_addr = l_addr;
			RD_R:    rd_addr = r_addr;
			default: rd_addr = bin_q;
		endcase
	end

	// spectrum memory
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[bin] <= magnitude;
		end
		rdata_q <= mem[rd_addr];
	end

	// curvature and slope terms
	assign dabs    = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
	assign diffabs = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign num_c   = diffabs[MAG_BITS-1:0];
	assign den_c   = {dabs[DEN_W-2:0], 1'b0};
	assign dividend = {1'b0, num_c, {FRAC_BITS{1'b0}}} + DVD_W'(dabs[DEN_W-2:0]);

	always_comb begin
		if (d_q == '0) begin
			mode_c = MODE_ZERO;
		end else if ({2'b0, num_c} > den_c) begin
			mode_c = MODE_SAT;
		end else begin
			mode_c = MODE_NORMAL;
		end
	end

	// restoring divider step
	assign trial = {rem_q, dvd_q[Q_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	// offset and index
	always_comb begin
		case (mode_q)
			MODE_ZERO: off = '0;
			MODE_SAT:  off = neg_q ? -(OFF_W'(1) <<< FRAC_BITS) : (OFF_W'(1) <<< FRAC_BITS);
			MODE_NORMAL: off = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
			default:   off = '0;
		endcase
	end

	assign base     = $signed({2'b0, bin_q, {FRAC_BITS{1'b0}}});
	assign prod_rnd = {1'b0, prod_q} + (PROD_W+1)'(1 << (RSH - 1));
	assign nlim     = $signed({1'b0, n_eff, {FRAC_BITS{1'b0}}});
	assign idx_w    = (idx_raw_q >= nlim) ? idx_raw_q - nlim : idx_raw_q;
	assign cv       = {c_q, 8'b0};

	always_comb begin
		value_c  = '0;
		status_c = ST_NORMAL;
		case (mode_q)
			MODE_ZERO: begin
				value_c  = {{VPAD{1'b0}}, cv};
				status_c = ST_ZERO;
			end
			MODE_SAT: begin
				value_c  = {{VPAD{1'b0}}, (neg_q ? l_q : r_q), 8'b0};
				status_c = ST_SAT;
			end
			MODE_NORMAL: begin
				if (!dneg_q) begin
					if (m_q > cv) begin
						value_c  = '0;
						status_c = ST_SAT;
					end else begin
						value_c = {{VPAD{1'b0}}, cv - m_q};
					end
				end else begin
					value_c = {{VPAD{1'b0}}, cv} + {{MPAD{1'b0}}, m_q};
				end
			end
			default: begin
				value_c  = '0;
				status_c = ST_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= bin;
		end
		if (cmd.cap_c) begin
			c_q <= rdata_q;
		end
		if (cmd.cap_l) begin
			l_q <= rdata_q;
		end
		if (cmd.cap_r) begin
			r_q <= rdata_q;
		end
		if (cmd.arith) begin
			d_q    <= $signed({3'b0, l_q}) + $signed({3'b0, r_q}) - $signed({2'b0, c_q, 1'b0});
			diff_q <= $signed({1'b0, l_q}) - $signed({1'b0, r_q});
		end
		if (cmd.setup) begin
			num_q  <= num_c;
			den_q  <= den_c;
			mode_q <= mode_c;
			neg_q  <= diff_q[DIFF_W-1] ^ d_q[D_W-1];
			dneg_q <= d_q[D_W-1];
			rem_q  <= DEN_W'(dividend[DVD_W-1:Q_W]);
			dvd_q  <= dividend[Q_W-1:0];
			q_q    <= '0;
			cnt_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			q_q   <= {q_q[Q_W-2:0], qbit};
			dvd_q <= {dvd_q[Q_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.mul) begin
			prod_q <= num_q * q_q;
		end
		if (cmd.rnd) begin
			m_q       <= prod_rnd[PROD_W:RSH];
			idx_raw_q <= base + IRAW_W'(off);
		end
		if (cmd.fin) begin
			if (stat.oob) begin
				value_q  <= '0;
				index_q  <= '0;
				status_q <= ST_RANGE;
			end else begin
				value_q  <= value_c;
				index_q  <= idx_w[IDX_W-1:0];
				status_q <= status_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.fin;
		end
	end

	assign stat.oob      = ({1'b0, bin_q} >= n_eff);
	assign stat.skip     = (mode_c != MODE_NORMAL);
	assign stat.div_done = (cnt_q == CNT_W'(Q_W - 1));

	assign result_valid = valid_q;
	assign peak_value   = value_q;
	assign peak_index   = index_q;
	assign status       = status_q;

endmodule

@@ hw/rtl/sppi_ctrl.sv @@
// controller: sequences memory writes and reads, fit, divider, multiply and result transfer
module sppi_ctrl import sppi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       operation,
	input  sppi_stat_t stat,
	output sppi_cmd_t  cmd,
	output logic       busy
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD_C  = 4'd1;
	localparam logic [3:0] S_RD_L  = 4'd2;
	localparam logic [3:0] S_RD_R  = 4'd3;
	localparam logic [3:0] S_CAP_R = 4'd4;
	localparam logic [3:0] S_ARITH = 4'd5;
	localparam logic [3:0] S_SETUP = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_MUL   = 4'd8;
	localparam logic [3:0] S_RND   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       take;

	assign take = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_C;
		state_d    = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.wr   = take && (operation == OP_WRITE);
				cmd.load = take && (operation == OP_QUERY);
				if (take && (operation == OP_QUERY)) begin
					state_d = S_RD_C;
				end
			end
			S_RD_C: begin
				cmd.rd_sel = RD_C;
				state_d    = stat.oob ? S_FIN : S_RD_L;
			end
			S_RD_L: begin
				cmd.rd_sel = RD_L;
				cmd.cap_c  = 1'b1;
				state_d    = S_RD_R;
			end
			S_RD_R: begin
				cmd.rd_sel = RD_R;
				cmd.cap_l  = 1'b1;
				state_d    = S_CAP_R;
			end
			S_CAP_R: begin
				cmd.cap_r = 1'b1;
				state_d   = S_ARITH;
			end
			S_ARITH: begin
				cmd.arith = 1'b1;
				state_d   = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = stat.skip ? S_RND : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy)
		else $error("query transfer did not make the block busy");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && stat.div_done |=> (state_q == S_MUL))
		else $error("divider did not hand over to multiply");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> !busy)
		else $error("controller not idle after result");

endmodule

@@ hw/rtl/spectral_peak_parabolic_interp_top.sv @@
// top level of the parabolic spectral peak interpolator
// write: completes at its accepting edge and gives no result; one write per cycle while idle
// query: states S_RD_C through the 17-step divider and S_MUL to S_RND and S_FIN, which registers
//   the result strobe; zero curvature or a saturated offset skips the divider and S_MUL, and an
//   out-of-range peak bin goes from S_RD_C to S_FIN; busy stays high and blocks new queries meanwhile
// reset clears the controller, the result strobe and the bin count (4096); memory is not cleared
module spectral_peak_parabolic_interp_top import sppi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                operation,
	input  logic [BIN_W-1:0]    bin,
	input  logic [MAG_BITS-1:0] magnitude,
	input  logic                cfg_we,
	input  logic [N_W-1:0]      cfg_wdata,
	output logic                result_valid,
	output logic [VAL_W-1:0]    peak_value,
	output logic [IDX_W-1:0]    peak_index,
	output logic [ST_W-1:0]     status
);

	sppi_cmd_t  cmd;
	sppi_stat_t stat;

	sppi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	sppi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.bin          (bin),
		.magnitude    (magnitude),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.peak_value   (peak_value),
		.peak_index   (peak_index),
		.status       (status)
	);

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_RANGE) |-> (peak_value == '0) && (peak_index == '0))
		else $error("out of range query gave nonzero result");

	a_zero_frac: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_ZERO) |-> (peak_index[FRAC_BITS-1:0] == '0))
		else $error("zero curvature result has a fractional index");

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a query in flight");

endmodule
